@@ rtl/galois_field_log_antilog_unit_assert.svh @@
// Assertion macros shared by the log/antilog unit RTL.
`ifndef GALOIS_FIELD_LOG_ANTILOG_UNIT_ASSERT_SVH
`define GALOIS_FIELD_LOG_ANTILOG_UNIT_ASSERT_SVH

// same-cycle implication
`define GFLA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gfla_pkg.sv @@
// Shared types and constants for the log/antilog unit.
package gfla_pkg;

  localparam int OPERAND_W = 8;
  localparam int RESULT_W  = 8;
  localparam int POLY_W    = 9;
  localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_ADD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    BLD_CLEAR = 3'b001,
    BLD_FILL  = 3'b010,
    BLD_DONE  = 3'b100
  } bld_state_t;

endpackage

@@ rtl/gfla_if.sv @@
// Operation and result channel interfaces.
interface gfla_op_if import gfla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_t                  operation;
  logic [OPERAND_W-1:0] operand_a;
  logic [OPERAND_W-1:0] operand_b;

  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface gfla_res_if import gfla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result_value;
  logic [RESULT_W-1:0] result_exponent;
  logic                result_is_zero;

  modport source (output valid, result_value, result_exponent, result_is_zero, input ready);
  modport sink   (input valid, result_value, result_exponent, result_is_zero, output ready);
endinterface

@@ rtl/gfla_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module gfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/gfla_builder.sv @@
// Table build sequencer: clears the log table, then walks the powers of x.
`include "galois_field_log_antilog_unit_assert.svh"

module gfla_builder import gfla_pkg::*; #(
  parameter int FIELD_SIZE = 256,
  localparam int VW = $clog2(FIELD_SIZE),
  localparam int EW = $clog2(FIELD_SIZE - 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [POLY_W-1:0] poly,
  output logic              done,
  output logic              exp_we,
  output logic [EW-1:0]     exp_waddr,
  output logic [VW-1:0]     exp_wdata,
  output logic              log_we,
  output logic [VW-1:0]     log_waddr,
  output logic [VW-1:0]     log_wdata
);

  localparam int SW = (VW + 1 > POLY_W) ? VW + 1 : POLY_W;
  localparam logic [VW-1:0] LAST_CLR  = VW'(FIELD_SIZE - 1);
  localparam logic [VW-1:0] LAST_FILL = VW'(FIELD_SIZE - 2);

  bld_state_t    state;
  logic [VW-1:0] count;
  logic [VW-1:0] run;
  logic [VW-1:0] run_next;
  logic [SW-1:0] shifted;
  logic [SW-1:0] reduced;

  // multiply by x, reduce once by the polynomial, then wrap into the field
  always_comb begin
    shifted  = SW'({run, 1'b0});
    reduced  = (shifted >= SW'(FIELD_SIZE)) ? (shifted ^ SW'(poly)) : shifted;
    run_next = VW'(reduced % FIELD_SIZE);
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= BLD_CLEAR;
      count <= '0;
      run   <= VW'(1);
    end else begin
      case (state)
        BLD_CLEAR: begin
          if (count == LAST_CLR) begin
            state <= BLD_FILL;
            count <= '0;
          end else begin
            count <= count + VW'(1);
          end
        end
        BLD_FILL: begin
          run <= run_next;
          if (count == LAST_FILL) begin
            state <= BLD_DONE;
          end else begin
            count <= count + VW'(1);
          end
        end
        BLD_DONE: begin
          state <= BLD_DONE;
        end
        default: begin
          state <= BLD_CLEAR;
          count <= '0;
          run   <= VW'(1);
        end
      endcase
    end
  end

  always_comb begin
    done      = (state == BLD_DONE);
    exp_we    = (state == BLD_FILL);
    exp_waddr = EW'(count);
    exp_wdata = run;
    log_we    = (state == BLD_CLEAR) || (state == BLD_FILL);
    log_waddr = (state == BLD_CLEAR) ? count : run;
    log_wdata = (state == BLD_CLEAR) ? '0 : count;
  end

  `GFLA_ASSERT_NOW(a_no_write_when_done, clk, rst, done, !exp_we && !log_we,
    "table write while tables marked done")
  `GFLA_ASSERT_NEXT(a_start_clears_done, clk, rst, start, !done,
    "tables still marked done after rebuild start")
  `GFLA_ASSERT_NEXT(a_fill_ends_done, clk, rst,
    (state == BLD_FILL) && (count == LAST_FILL) && !start, done,
    "last fill step did not finish the build")

endmodule

@@ rtl/gfla_pipe.sv @@
// Item pipeline: log lookups, exponent add mod order (multiply) or XOR (add), antilog lookup, output register.
`include "galois_field_log_antilog_unit_assert.svh"

module gfla_pipe import gfla_pkg::*; #(
  parameter int FIELD_SIZE = 256,
  localparam int VW = $clog2(FIELD_SIZE),
  localparam int EW = $clog2(FIELD_SIZE - 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          tables_ready,
  gfla_op_if.sink       req,
  gfla_res_if.source    rsp,
  output logic          log_re,
  output logic [VW-1:0] log_raddr_a,
  output logic [VW-1:0] log_raddr_b,
  input  logic [VW-1:0] log_rdata_a,
  input  logic [VW-1:0] log_rdata_b,
  output logic          exp_re,
  output logic [EW-1:0] exp_raddr,
  input  logic [VW-1:0] exp_rdata
);

  localparam logic [VW:0] ORDER = (VW + 1)'(FIELD_SIZE - 1);

  logic en1, en2, en_o, take;

  // stage 0
  logic [VW-1:0] a_r, b_r, x_r;
  logic          is_mul;

  // stage 1: log table data valid
  logic          v1, s1_mul, s1_zero, s1_a_one, s1_b_one, s1_x_one;
  logic [VW-1:0] s1_val;
  logic [VW-1:0] la, lb, add_ex;
  logic [VW:0]   sum, sum_mod;

  // stage 2: antilog data valid
  logic          v2, s2_mul, s2_zero;
  logic [VW-1:0] s2_val, s2_ex;
  logic [VW-1:0] fin_val, fin_ex;

  // output register
  logic                out_valid;
  logic [RESULT_W-1:0] res_value, res_exponent;
  logic                res_is_zero;

  always_comb begin
    en_o      = !out_valid || rsp.ready;
    en2       = !v2 || en_o;
    en1       = !v1 || en2;
    req.ready = tables_ready && en1;
    take      = req.valid && req.ready;

    a_r    = VW'(32'(req.operand_a) % FIELD_SIZE);
    b_r    = VW'(32'(req.operand_b) % FIELD_SIZE);
    x_r    = a_r ^ b_r;
    is_mul = (req.operation == OP_MUL);

    log_re      = en1;
    log_raddr_a = is_mul ? a_r : x_r;
    log_raddr_b = b_r;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mul   <= is_mul;
      s1_zero  <= (a_r == '0) || (b_r == '0);
      s1_val   <= x_r;
      s1_a_one <= (a_r == VW'(1));
      s1_b_one <= (b_r == VW'(1));
      s1_x_one <= (x_r == VW'(1));
    end
  end

  // the log of one is zero whatever the build left in that entry
  always_comb begin
    la      = s1_a_one ? '0 : log_rdata_a;
    lb      = s1_b_one ? '0 : log_rdata_b;
    sum     = {1'b0, la} + {1'b0, lb};
    sum_mod = (sum >= ORDER) ? (sum - ORDER) : sum;
    add_ex  = ((s1_val == '0) || s1_x_one) ? '0 : log_rdata_a;

    exp_re    = en2;
    exp_raddr = EW'(sum_mod);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mul  <= s1_mul;
      s2_zero <= s1_zero;
      s2_val  <= s1_val;
      s2_ex   <= s1_mul ? VW'(sum_mod) : add_ex;
    end
  end

  always_comb begin
    fin_val = s2_mul ? (s2_zero ? '0 : exp_rdata) : s2_val;
    fin_ex  = (s2_mul && (s2_zero || (exp_rdata == '0))) ? '0 : s2_ex;
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      res_value    <= RESULT_W'(fin_val);
      res_exponent <= RESULT_W'(fin_ex);
      res_is_zero  <= (fin_val == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= take;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en_o) begin
        out_valid <= v2;
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_value    = res_value;
  assign rsp.result_exponent = res_exponent;
  assign rsp.result_is_zero  = res_is_zero;

  `GFLA_ASSERT_NEXT(a_take_fills_s1, clk, rst, take, v1,
    "accepted word did not enter the first stage")
  `GFLA_ASSERT_NOW(a_no_take_during_build, clk, rst, !tables_ready, !req.ready,
    "ready raised while tables are being built")
  `GFLA_ASSERT_NEXT(a_s2_holds, clk, rst, v2 && !en2,
    v2 && $stable(s2_ex) && $stable(s2_val),
    "stalled second stage lost its word")

endmodule

@@ rtl/galois_field_log_antilog_unit.sv @@
// Top level of the GF(2^m) log/antilog arithmetic unit.
// Multiplies (exponent add modulo FIELD_SIZE-1 through log and antilog tables) or
// adds (XOR) two field elements, one word per clock once the tables are built and
// while a low rsp.ready does not stall the output register. An accepted word passes
// the log table read at the accepting edge, the exponent add with antilog read, and
// the result select into the output register. After reset and after every write of
// field_polynomial (APB byte address 0 to 3) the block clears the log table and then
// steps through the powers of x, one table entry per cycle; req.ready stays low in it.
// The rate is set by the single write port of each table memory during that build, and
// by one lookup per stage afterwards. Reads at paddr 0 to 3 return the polynomial;
// addresses 4 to 7 read zero.
module galois_field_log_antilog_unit import gfla_pkg::*; #(
  parameter int FIELD_SIZE = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  gfla_op_if.sink           req,
  gfla_res_if.source        rsp
);

  localparam int VW = $clog2(FIELD_SIZE);
  localparam int EW = $clog2(FIELD_SIZE - 1);
  localparam logic REG_FIELD_POLY = 1'b0;

  logic [POLY_W-1:0] field_polynomial;
  logic              poly_wr;

  logic          tables_ready;
  logic          exp_we, log_we, log_re, exp_re;
  logic [EW-1:0] exp_waddr, exp_raddr;
  logic [VW-1:0] exp_wdata, log_waddr, log_wdata;
  logic [VW-1:0] log_raddr_a, log_raddr_b, log_rdata_a, log_rdata_b, exp_rdata;

  assign pready  = 1'b1;
  assign poly_wr = psel && penable && pwrite && (paddr[2] == REG_FIELD_POLY);
  assign prdata  = (paddr[2] == REG_FIELD_POLY) ? APB_DW'(field_polynomial) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_polynomial <= POLY_RESET;
    end else if (poly_wr) begin
      field_polynomial <= pwdata[POLY_W-1:0];
    end
  end

  gfla_builder #(.FIELD_SIZE(FIELD_SIZE)) u_builder (
    .clk       (clk),
    .rst       (rst),
    .start     (poly_wr),
    .poly      (field_polynomial),
    .done      (tables_ready),
    .exp_we    (exp_we),
    .exp_waddr (exp_waddr),
    .exp_wdata (exp_wdata),
    .log_we    (log_we),
    .log_waddr (log_waddr),
    .log_wdata (log_wdata)
  );

  gfla_ram #(.WIDTH(VW), .DEPTH(FIELD_SIZE - 1)) u_exp_ram (
    .clk     (clk),
    .we      (exp_we),
    .waddr   (exp_waddr),
    .wdata   (exp_wdata),
    .re      (exp_re),
    .raddr_a (exp_raddr),
    .raddr_b (exp_raddr),
    .rdata_a (exp_rdata),
    .rdata_b ()
  );

  gfla_ram #(.WIDTH(VW), .DEPTH(FIELD_SIZE)) u_log_ram (
    .clk     (clk),
    .we      (log_we),
    .waddr   (log_waddr),
    .wdata   (log_wdata),
    .re      (log_re),
    .raddr_a (log_raddr_a),
    .raddr_b (log_raddr_b),
    .rdata_a (log_rdata_a),
    .rdata_b (log_rdata_b)
  );

  gfla_pipe #(.FIELD_SIZE(FIELD_SIZE)) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .tables_ready (tables_ready),
    .req          (req),
    .rsp          (rsp),
    .log_re       (log_re),
    .log_raddr_a  (log_raddr_a),
    .log_raddr_b  (log_raddr_b),
    .log_rdata_a  (log_rdata_a),
    .log_rdata_b  (log_rdata_b),
    .exp_re       (exp_re),
    .exp_raddr    (exp_raddr),
    .exp_rdata    (exp_rdata)
  );

endmodule
